// ===== rtl/hmf_pkg.sv =====
// ----------------------------------------------------------------------------
// hmf_pkg
// Shared types and constants of the histogram mode finder.
// ----------------------------------------------------------------------------
package hmf_pkg;

  localparam int NUM_BINS      = 32;
  localparam int MAX_ITEMS     = 1024;
  localparam int ValueW        = 5;
  localparam int CountW        = 11;
  localparam int CountFieldMax = (1 << CountW) - 1;

  // only bins below 2**ValueW can ever be hit by a sample
  localparam int NumBinsEff = (NUM_BINS < (1 << ValueW)) ? NUM_BINS : (1 << ValueW);
  localparam int AddrW      = $clog2(NumBinsEff);
  localparam int CountCap   = (MAX_ITEMS > CountFieldMax) ? CountFieldMax : MAX_ITEMS;

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [1:0] {
    OP_INC,
    OP_MAX,
    OP_EQ
  } alu_op_e;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    count_t wdata;
    addr_t  raddr;
    logic   clear;
  } ram_req_t;

  typedef struct packed {
    count_t val;
    logic   hit;
  } alu_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT_RD,
    ST_EMIT_CHK,
    ST_FLUSH
  } state_e;

endpackage

// ===== rtl/hmf_if.sv =====
// ----------------------------------------------------------------------------
// hmf_if
// Valid/ready channels: sample items in, mode items out.
// ----------------------------------------------------------------------------
interface hmf_in_if import hmf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] sample_value;
  logic              set_end;

  modport source (output valid, output sample_value, output set_end, input ready);
  modport sink   (input valid, input sample_value, input set_end, output ready);
endinterface

interface hmf_out_if import hmf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] mode_value;
  logic [CountW-1:0] mode_count;
  logic              last_mode;

  modport source (output valid, output mode_value, output mode_count, output last_mode,
                  input ready);
  modport sink   (input valid, input mode_value, input mode_count, input last_mode,
                  output ready);
endinterface

// ===== rtl/hmf_bin_ram.sv =====
// ----------------------------------------------------------------------------
// hmf_bin_ram
// Histogram bin store: one write port, one registered read port, and a valid
// bit per entry so that reset and end of set clear all bins at once.
// ----------------------------------------------------------------------------
module hmf_bin_ram import hmf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ram_req_t req_i,
  output count_t   rdata_o
);

  count_t                mem [NumBinsEff];
  logic [NumBinsEff-1:0] valid_q;
  count_t                rdata_q;
  logic                  rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[req_i.raddr];
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  // an entry never written since the last clear reads as zero
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/hmf_alu.sv =====
// ----------------------------------------------------------------------------
// hmf_alu
// Shared count unit: saturating increment, running maximum, tie compare.
// ----------------------------------------------------------------------------
module hmf_alu import hmf_pkg::*; (
  input  alu_op_e  op_i,
  input  count_t   a_i,
  input  count_t   b_i,
  output alu_res_t res_o
);

  localparam count_t CapC = count_t'(CountCap);

  always_comb begin
    res_o = '0;
    unique case (op_i)
      OP_INC: begin
        res_o.hit = (a_i < CapC);
        res_o.val = res_o.hit ? a_i + count_t'(1) : a_i;
      end
      OP_MAX: begin
        res_o.hit = (a_i > b_i);
        res_o.val = res_o.hit ? a_i : b_i;
      end
      OP_EQ: begin
        res_o.hit = (a_i == b_i) && (b_i != '0);
        res_o.val = a_i;
      end
      default: res_o = '0;
    endcase
  end

endmodule

// ===== rtl/histogram_mode_finder.sv =====
// ----------------------------------------------------------------------------
// histogram_mode_finder
// Counts a set of samples and reports every most frequent value with ties.
// ----------------------------------------------------------------------------
// Each in-range sample is read from its bin, then written back incremented
// through the bin RAM and the shared count unit; ready is low during the
// write-back. After the sample marked set_end the block walks the bins twice,
// reading then checking each bin: once for the highest count, once to emit
// each bin holding it, in ascending order, then ST_FLUSH sends the final mode.
// A low ready on the output can stall the emit walk and the final send. An
// empty set emits nothing. Bins clear at once at reset and at set end through
// per-bin valid bits; there is no clearing pass.
// ----------------------------------------------------------------------------
module histogram_mode_finder import hmf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  hmf_in_if.sink   sample_i,
  hmf_out_if.source mode_o
);

  localparam addr_t LastIdx = addr_t'(NumBinsEff - 1);
  localparam logic [ValueW:0] BinLimit = (ValueW + 1)'(NumBinsEff);

  state_e   state_q, state_d;
  addr_t    idx_q, idx_d;
  addr_t    addr_q, addr_d;
  logic     end_q, end_d;
  count_t   top_q, top_d;
  addr_t    pend_idx_q, pend_idx_d;
  logic     pend_vld_q, pend_vld_d;

  logic              out_vld_q;
  logic [ValueW-1:0] out_val_q;
  count_t            out_cnt_q;
  logic              out_last_q;
  logic              out_free;
  logic              out_ld;
  logic              out_ld_last;

  ram_req_t ram_req;
  count_t   rdata;
  alu_op_e  alu_op;
  alu_res_t alu_res;
  logic     in_range;

  hmf_bin_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  hmf_alu u_alu (
    .op_i  (alu_op),
    .a_i   (rdata),
    .b_i   (top_q),
    .res_o (alu_res)
  );

  assign out_free = !out_vld_q || mode_o.ready;
  assign in_range = ({1'b0, sample_i.sample_value} < BinLimit);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    end_d       = end_q;
    top_d       = top_q;
    pend_idx_d  = pend_idx_q;
    pend_vld_d  = pend_vld_q;
    out_ld      = 1'b0;
    out_ld_last = 1'b0;
    alu_op      = OP_MAX;
    ram_req       = '0;
    ram_req.raddr = idx_q;
    sample_i.ready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        sample_i.ready = 1'b1;
        ram_req.raddr  = addr_t'(sample_i.sample_value);
        if (sample_i.valid) begin
          addr_d = addr_t'(sample_i.sample_value);
          end_d  = sample_i.set_end;
          if (in_range) begin
            state_d = ST_CNT_WR;
          end else if (sample_i.set_end) begin
            idx_d   = '0;
            top_d   = '0;
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_CNT_WR: begin
        alu_op        = OP_INC;
        ram_req.we    = 1'b1;
        ram_req.waddr = addr_q;
        ram_req.wdata = alu_res.val;
        if (end_q) begin
          idx_d   = '0;
          top_d   = '0;
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        alu_op = OP_MAX;
        top_d  = alu_res.val;
        if (idx_q == LastIdx) begin
          idx_d      = '0;
          pend_vld_d = 1'b0;
          if (alu_res.val == '0) begin
            // empty set: no mode
            ram_req.clear = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end else begin
          idx_d   = idx_q + addr_t'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT_CHK;
      ST_EMIT_CHK: begin
        alu_op = OP_EQ;
        // a tie holds back the previous match until the output can take it
        if (!(alu_res.hit && pend_vld_q && !out_free)) begin
          if (alu_res.hit) begin
            out_ld     = pend_vld_q;
            pend_idx_d = idx_q;
            pend_vld_d = 1'b1;
          end
          if (idx_q == LastIdx) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d   = idx_q + addr_t'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_ld        = pend_vld_q;
          out_ld_last   = 1'b1;
          pend_vld_d    = 1'b0;
          ram_req.clear = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      end_q      <= 1'b0;
      top_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      end_q      <= end_d;
      top_q      <= top_d;
      pend_vld_q <= pend_vld_d;
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (mode_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    pend_idx_q <= pend_idx_d;
    if (out_ld) begin
      out_val_q  <= ValueW'(pend_idx_q);
      out_cnt_q  <= top_q;
      out_last_q <= out_ld_last;
    end
  end

  assign mode_o.valid      = out_vld_q;
  assign mode_o.mode_value = out_val_q;
  assign mode_o.mode_count = out_cnt_q;
  assign mode_o.last_mode  = out_last_q;

  a_mode_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_o.valid |-> (mode_o.mode_count != '0))
    else $error("mode item with zero count");

  a_tie_sent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_CHK) && alu_res.hit && pend_vld_q && out_free
    |=> mode_o.valid && !mode_o.last_mode)
    else $error("tie not forwarded as non-final mode");

  a_final_sent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) && out_free && pend_vld_q
    |=> mode_o.valid && mode_o.last_mode && (state_q == ST_IDLE))
    else $error("final mode not flagged");

  a_busy_no_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN_CHK) || (state_q == ST_EMIT_CHK) || (state_q == ST_FLUSH))
    |-> !sample_i.ready)
    else $error("sample accepted during bin walk");

endmodule
